// ===== sv/scjf_pkg.sv =====
// ----------------------------------------------------------------------------
// scjf_pkg: shared types and constants of the serial camera JPEG fetch core
// Holds the job descriptor passed from the front to the back end, the
// camera command and reply tables, and the result codes.
// ----------------------------------------------------------------------------
package scjf_pkg;

    localparam int CHUNK_BYTES_DEF = 32;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int POS_W = 6;
    localparam int IDX_W = 6;

    localparam int CMD_LEN        = 5;
    localparam int SIZE_HDR_LEN   = 7;
    localparam int SIZE_REPLY_LEN = 9;
    localparam int FRAME_LEN      = 5;
    localparam int CHUNK_CMD_LEN  = 16;

    localparam logic OP_START = 1'b0;
    localparam logic OP_BYTE  = 1'b1;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_TX     = 2'd0;
    localparam kind_t KIND_IMAGE  = 2'd1;
    localparam kind_t KIND_STATUS = 2'd2;

    typedef logic [2:0] status_t;
    localparam status_t ST_CAP_FAIL = 3'd0;
    localparam status_t ST_SIZE_BAD = 3'd1;
    localparam status_t ST_HEAD_BAD = 3'd2;
    localparam status_t ST_FOOT_BAD = 3'd3;
    localparam status_t ST_DONE     = 3'd4;
    localparam status_t ST_SIZE     = 3'd5;
    localparam status_t ST_NONE     = 3'd0;

    typedef logic [2:0] job_op_t;
    localparam job_op_t JOB_CAP_CMD  = 3'd0;
    localparam job_op_t JOB_CAP_FAIL = 3'd1;
    localparam job_op_t JOB_SIZE_CMD = 3'd2;
    localparam job_op_t JOB_SIZE     = 3'd3;
    localparam job_op_t JOB_ZERO     = 3'd4;
    localparam job_op_t JOB_IMAGE    = 3'd5;
    localparam job_op_t JOB_FOOT     = 3'd6;

    typedef struct packed {
        job_op_t     op;
        logic        mism;
        logic        fin;
        logic [7:0]  data;
        logic [15:0] size;
        logic [15:0] addr;
        logic [15:0] count;
    } job_t;

    function automatic logic [7:0] cap_cmd_byte(input logic [2:0] i);
        logic [7:0] v;
        case (i)
            3'd0:    v = 8'h56;
            3'd2:    v = 8'h36;
            3'd3:    v = 8'h01;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] cap_ok_byte(input logic [2:0] i);
        logic [7:0] v;
        case (i)
            3'd0:    v = 8'h76;
            3'd2:    v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] size_cmd_byte(input logic [2:0] i);
        logic [7:0] v;
        case (i)
            3'd0:    v = 8'h56;
            3'd2:    v = 8'h34;
            3'd3:    v = 8'h01;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] size_ok_byte(input logic [2:0] i);
        logic [7:0] v;
        case (i)
            3'd0:    v = 8'h76;
            3'd2:    v = 8'h34;
            3'd4:    v = 8'h04;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] frame_ok_byte(input logic [2:0] i);
        logic [7:0] v;
        case (i)
            3'd0:    v = 8'h76;
            3'd2:    v = 8'h32;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] chunk_cmd_byte(input logic [3:0] i,
                                                  input logic [15:0] addr,
                                                  input logic [15:0] len);
        logic [7:0] v;
        case (i)
            4'd0:    v = 8'h56;
            4'd2:    v = 8'h32;
            4'd3:    v = 8'h0C;
            4'd5:    v = 8'h0A;
            4'd8:    v = addr[15:8];
            4'd9:    v = addr[7:0];
            4'd12:   v = len[15:8];
            4'd13:   v = len[7:0];
            4'd15:   v = 8'h0A;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/scjf_front.sv =====
// ----------------------------------------------------------------------------
// scjf_front: session tracker
// Takes start and received-byte transfers, checks camera replies, tracks
// the readout address, image count and end mark, and posts one job per
// transfer that produces results.
// ----------------------------------------------------------------------------
module scjf_front #(
    parameter int CHUNK_BYTES = scjf_pkg::CHUNK_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_accept,
    input  logic              in_op,
    input  logic [7:0]        in_byte,
    output logic              job_push,
    output scjf_pkg::job_t    job
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_CAP  = 3'd1;
    localparam logic [2:0] PH_SIZE = 3'd2;
    localparam logic [2:0] PH_HEAD = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_FOOT = 3'd5;

    localparam logic [scjf_pkg::POS_W-1:0] CAP_END  = scjf_pkg::POS_W'(scjf_pkg::CMD_LEN - 1);
    localparam logic [scjf_pkg::POS_W-1:0] SIZE_HDR = scjf_pkg::POS_W'(scjf_pkg::SIZE_HDR_LEN);
    localparam logic [scjf_pkg::POS_W-1:0] SIZE_END =
        scjf_pkg::POS_W'(scjf_pkg::SIZE_REPLY_LEN - 1);
    localparam logic [scjf_pkg::POS_W-1:0] FRAME_END =
        scjf_pkg::POS_W'(scjf_pkg::FRAME_LEN - 1);
    localparam logic [scjf_pkg::POS_W-1:0] DATA_END = scjf_pkg::POS_W'(CHUNK_BYTES - 1);
    localparam logic [15:0] CHUNK_LEN = 16'(CHUNK_BYTES);

    logic [2:0]                 phase_reg, phase_next;
    logic [scjf_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [15:0]                addr_reg, addr_next;
    logic [15:0]                size_reg, size_next;
    logic [7:0]                 prev_reg, prev_next;
    logic                       end_reg, end_next;
    logic                       mism_reg, mism_next;
    logic [15:0]                count_reg, count_next;

    logic                       mism_c;
    logic [15:0]                size_c;
    logic [scjf_pkg::POS_W-1:0] pos_inc;

    assign pos_inc = pos_reg + 1'b1;

    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        addr_next  = addr_reg;
        size_next  = size_reg;
        prev_next  = prev_reg;
        end_next   = end_reg;
        mism_next  = mism_reg;
        count_next = count_reg;
        job_push   = 1'b0;
        job        = '0;
        mism_c     = mism_reg;
        size_c     = size_reg;
        job.count  = count_reg;
        job.addr   = addr_reg;
        if (in_accept) begin
            if (in_op == scjf_pkg::OP_START) begin
                phase_next = PH_CAP;
                pos_next   = '0;
                addr_next  = '0;
                size_next  = '0;
                prev_next  = '0;
                end_next   = 1'b0;
                mism_next  = 1'b0;
                count_next = '0;
                job_push   = 1'b1;
                job.op     = scjf_pkg::JOB_CAP_CMD;
                job.count  = '0;
            end else begin
                unique case (phase_reg)
                    PH_CAP: begin
                        mism_c = mism_reg | (in_byte != scjf_pkg::cap_ok_byte(pos_reg[2:0]));
                        if (pos_reg == CAP_END) begin
                            pos_next  = '0;
                            mism_next = 1'b0;
                            job_push  = 1'b1;
                            if (mism_c) begin
                                job.op     = scjf_pkg::JOB_CAP_FAIL;
                                phase_next = PH_IDLE;
                            end else begin
                                job.op     = scjf_pkg::JOB_SIZE_CMD;
                                phase_next = PH_SIZE;
                            end
                        end else begin
                            pos_next  = pos_inc;
                            mism_next = mism_c;
                        end
                    end
                    PH_SIZE: begin
                        if (pos_reg < SIZE_HDR) begin
                            mism_c = mism_reg |
                                     (in_byte != scjf_pkg::size_ok_byte(pos_reg[2:0]));
                        end else if (pos_reg == SIZE_HDR) begin
                            size_c = {in_byte, 8'h00};
                        end else begin
                            size_c = {size_reg[15:8], size_reg[7:0] | in_byte};
                        end
                        if (pos_reg == SIZE_END) begin
                            pos_next   = '0;
                            mism_next  = 1'b0;
                            size_next  = mism_c ? 16'h0000 : size_c;
                            phase_next = PH_HEAD;
                            job_push   = 1'b1;
                            job.op     = scjf_pkg::JOB_SIZE;
                            job.mism   = mism_c;
                            job.size   = mism_c ? 16'h0000 : size_c;
                        end else begin
                            pos_next  = pos_inc;
                            mism_next = mism_c;
                            size_next = size_c;
                        end
                    end
                    PH_HEAD: begin
                        mism_c = mism_reg |
                                 (in_byte != scjf_pkg::frame_ok_byte(pos_reg[2:0]));
                        if (pos_reg == FRAME_END) begin
                            pos_next  = '0;
                            mism_next = 1'b0;
                            if (mism_c) begin
                                job_push   = 1'b1;
                                job.op     = scjf_pkg::JOB_ZERO;
                                job.fin    = end_reg;
                                phase_next = PH_FOOT;
                                if (!end_reg) begin
                                    count_next = count_reg + CHUNK_LEN;
                                    prev_next  = 8'h00;
                                end
                            end else begin
                                phase_next = PH_DATA;
                            end
                        end else begin
                            pos_next  = pos_inc;
                            mism_next = mism_c;
                        end
                    end
                    PH_DATA: begin
                        if (!end_reg) begin
                            count_next = count_reg + 16'd1;
                            job_push   = 1'b1;
                            job.op     = scjf_pkg::JOB_IMAGE;
                            job.data   = in_byte;
                            job.count  = count_reg + 16'd1;
                            end_next   = (prev_reg == 8'hFF) && (in_byte == 8'hD9);
                            prev_next  = in_byte;
                        end
                        if (pos_reg == DATA_END) begin
                            pos_next   = '0;
                            phase_next = PH_FOOT;
                        end else begin
                            pos_next = pos_inc;
                        end
                    end
                    PH_FOOT: begin
                        mism_c = mism_reg |
                                 (in_byte != scjf_pkg::frame_ok_byte(pos_reg[2:0]));
                        if (pos_reg == FRAME_END) begin
                            pos_next  = '0;
                            mism_next = 1'b0;
                            job_push  = 1'b1;
                            job.op    = scjf_pkg::JOB_FOOT;
                            job.mism  = mism_c;
                            job.fin   = end_reg;
                            if (end_reg) begin
                                phase_next = PH_IDLE;
                            end else begin
                                addr_next  = addr_reg + CHUNK_LEN;
                                job.addr   = addr_reg + CHUNK_LEN;
                                phase_next = PH_HEAD;
                            end
                        end else begin
                            pos_next  = pos_inc;
                            mism_next = mism_c;
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                        pos_next   = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            pos_reg   <= '0;
            addr_reg  <= '0;
            size_reg  <= '0;
            prev_reg  <= '0;
            end_reg   <= 1'b0;
            mism_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            addr_reg  <= addr_next;
            size_reg  <= size_next;
            prev_reg  <= prev_next;
            end_reg   <= end_next;
            mism_reg  <= mism_next;
            count_reg <= count_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        job_push |-> in_accept)
        else $error("job posted without an input transfer");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DATA) |-> (pos_reg <= DATA_END))
        else $error("data position beyond chunk length");

endmodule

// ===== sv/scjf_queue.sv =====
// ----------------------------------------------------------------------------
// scjf_queue: job queue
// Short first-in first-out buffer of job descriptors between the front
// and the back end.
// ----------------------------------------------------------------------------
module scjf_queue #(
    parameter int DEPTH = scjf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  scjf_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output scjf_pkg::job_t head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);

    scjf_pkg::job_t       mem_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;

    assign full     = (cnt_reg == DEPTH_CNT);
    assign empty    = (cnt_reg == '0);
    assign head_job = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("job queue overflow");

    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("job queue underflow");

endmodule

// ===== sv/scjf_back.sv =====
// ----------------------------------------------------------------------------
// scjf_back: result sequencer
// Expands each job into its run of result transfers, one per cycle unless
// m_tready stalls, into a registered output stage.
// ----------------------------------------------------------------------------
module scjf_back #(
    parameter int CHUNK_BYTES = scjf_pkg::CHUNK_BYTES_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_empty,
    input  scjf_pkg::job_t q_job,
    output logic           q_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [47:0]    m_tdata,
    output logic [1:0]     m_tuser,
    output logic           m_tlast
);

    localparam logic [scjf_pkg::IDX_W-1:0] CHUNK_IDX = scjf_pkg::IDX_W'(CHUNK_BYTES);
    localparam logic [scjf_pkg::IDX_W-1:0] CMD_END   = scjf_pkg::IDX_W'(scjf_pkg::CMD_LEN - 1);
    localparam logic [scjf_pkg::IDX_W-1:0] SIZE_END  = scjf_pkg::IDX_W'(scjf_pkg::CHUNK_CMD_LEN);
    localparam logic [scjf_pkg::IDX_W-1:0] CCMD_END  =
        scjf_pkg::IDX_W'(scjf_pkg::CHUNK_CMD_LEN - 1);
    localparam logic [15:0] CHUNK_LEN = 16'(CHUNK_BYTES);

    scjf_pkg::job_t             job_reg;
    logic                       busy_reg;
    logic [scjf_pkg::IDX_W-1:0] idx_reg;

    logic                       out_valid_reg;
    scjf_pkg::kind_t            out_kind_reg;
    logic [7:0]                 out_data_reg;
    scjf_pkg::status_t          out_status_reg;
    logic [15:0]                out_size_reg;
    logic [15:0]                out_count_reg;
    logic                       out_last_reg;

    scjf_pkg::kind_t            res_kind;
    logic [7:0]                 res_data;
    scjf_pkg::status_t          res_status;
    logic [15:0]                res_size;
    logic [15:0]                res_count;
    logic                       res_last;
    logic [scjf_pkg::IDX_W-1:0] step;
    logic [scjf_pkg::IDX_W-1:0] cmd_step;
    logic                       load;

    assign step     = idx_reg - scjf_pkg::IDX_W'(job_reg.mism);
    assign cmd_step = idx_reg - 1'b1;

    always_comb begin
        res_kind   = scjf_pkg::KIND_TX;
        res_data   = 8'h00;
        res_status = scjf_pkg::ST_NONE;
        res_size   = 16'h0000;
        res_count  = job_reg.count;
        res_last   = 1'b0;
        unique case (job_reg.op)
            scjf_pkg::JOB_CAP_CMD: begin
                res_data = scjf_pkg::cap_cmd_byte(idx_reg[2:0]);
                res_last = (idx_reg == CMD_END);
            end
            scjf_pkg::JOB_SIZE_CMD: begin
                res_data = scjf_pkg::size_cmd_byte(idx_reg[2:0]);
                res_last = (idx_reg == CMD_END);
            end
            scjf_pkg::JOB_CAP_FAIL: begin
                res_kind   = scjf_pkg::KIND_STATUS;
                res_status = scjf_pkg::ST_CAP_FAIL;
                res_last   = 1'b1;
            end
            scjf_pkg::JOB_SIZE: begin
                if (idx_reg == '0) begin
                    res_kind   = scjf_pkg::KIND_STATUS;
                    res_status = job_reg.mism ? scjf_pkg::ST_SIZE_BAD : scjf_pkg::ST_SIZE;
                    res_size   = job_reg.size;
                end else begin
                    res_data = scjf_pkg::chunk_cmd_byte(cmd_step[3:0], job_reg.addr,
                                                        CHUNK_LEN);
                    res_last = (idx_reg == SIZE_END);
                end
            end
            scjf_pkg::JOB_ZERO: begin
                if (idx_reg == '0) begin
                    res_kind   = scjf_pkg::KIND_STATUS;
                    res_status = scjf_pkg::ST_HEAD_BAD;
                    res_last   = job_reg.fin;
                end else begin
                    res_kind  = scjf_pkg::KIND_IMAGE;
                    res_count = job_reg.count + 16'(idx_reg);
                    res_last  = (idx_reg == CHUNK_IDX);
                end
            end
            scjf_pkg::JOB_IMAGE: begin
                res_kind = scjf_pkg::KIND_IMAGE;
                res_data = job_reg.data;
                res_last = 1'b1;
            end
            scjf_pkg::JOB_FOOT: begin
                if (job_reg.mism && (idx_reg == '0)) begin
                    res_kind   = scjf_pkg::KIND_STATUS;
                    res_status = scjf_pkg::ST_FOOT_BAD;
                end else if (job_reg.fin) begin
                    res_kind   = scjf_pkg::KIND_STATUS;
                    res_status = scjf_pkg::ST_DONE;
                    res_last   = 1'b1;
                end else begin
                    res_data = scjf_pkg::chunk_cmd_byte(step[3:0], job_reg.addr, CHUNK_LEN);
                    res_last = (step == CCMD_END);
                end
            end
            default: begin
                res_last = 1'b1;
            end
        endcase
    end

    assign load  = busy_reg && (!out_valid_reg || m_tready);
    assign q_pop = !q_empty && (!busy_reg || (load && res_last));

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            job_reg <= q_job;
        end
        if (load) begin
            out_kind_reg   <= res_kind;
            out_data_reg   <= res_data;
            out_status_reg <= res_status;
            out_size_reg   <= res_size;
            out_count_reg  <= res_count;
            out_last_reg   <= res_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end else if (load && res_last) begin
                busy_reg <= 1'b0;
                idx_reg  <= '0;
            end else if (load) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {5'b00000, out_count_reg, out_size_reg, out_status_reg, out_data_reg};

    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (idx_reg <= CHUNK_IDX) || (idx_reg <= SIZE_END))
        else $error("result index past the longest run");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (load && !res_last) |=> busy_reg)
        else $error("sequencer dropped a run before its last result");

endmodule

// ===== sv/serial_camera_jpeg_fetch_core.sv =====
// ----------------------------------------------------------------------------
// serial_camera_jpeg_fetch_core: serial camera JPEG readout session
// Drives capture, size query and chunked image reads from received bytes,
// producing bytes to transmit, image bytes and status reports.
//
//   channel  dir  tdata                 tuser        tlast
//   s_       in   [7:0] rx_byte         [0] opcode   -
//   m_       out  data_byte, status,    [1:0] kind   last
//                 image_size, count
//
// The front end takes one transfer per cycle while the queue is not full
// and posts a job per transfer that yields results; the back end emits one
// result per cycle unless m_tready stalls it. The sequencer sets each run to
// 1 to 33 results at the default; the job queue holds QUEUE_DEPTH runs.
// Reset clears session state, the queue and the output stage.
// s_tready falls only when the job queue is full; m_tready stalls hold the
// output stage and the sequencer.
// ----------------------------------------------------------------------------
module serial_camera_jpeg_fetch_core #(
    parameter int CHUNK_BYTES = scjf_pkg::CHUNK_BYTES_DEF,
    parameter int QUEUE_DEPTH = scjf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [0:0]  s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] data_byte, [10:8] status,
                                   // [26:11] image_size, [42:27] bytes_emitted
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast
);

    logic           in_accept;
    logic           job_push;
    scjf_pkg::job_t job;
    logic           q_full;
    logic           q_empty;
    logic           q_pop;
    scjf_pkg::job_t q_job;

    assign s_tready  = !q_full;
    assign in_accept = s_tvalid && s_tready;

    scjf_front #(
        .CHUNK_BYTES(CHUNK_BYTES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_op     (s_tuser[0]),
        .in_byte   (s_tdata),
        .job_push  (job_push),
        .job       (job)
    );

    scjf_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (job_push),
        .push_job (job),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head_job (q_job)
    );

    scjf_back #(
        .CHUNK_BYTES(CHUNK_BYTES)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_job    (q_job),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== dv/serial_camera_jpeg_fetch_core_checker.sv =====
// ----------------------------------------------------------------------------
// serial_camera_jpeg_fetch_core_checker: result checker of the JPEG fetch core
// Watches both stream channels. Every accepted input transfer is run through
// a session model of the camera readout. The model covers capture, the size
// query, chunk reads, zero fill on a bad header and end-of-image detection.
// Its results are queued, and each accepted output transfer is compared
// field by field with the oldest queued result.
// ----------------------------------------------------------------------------
module serial_camera_jpeg_fetch_core_checker #(
    parameter int CHUNK_BYTES = scjf_pkg::CHUNK_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic [0:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending,
    output int          results_checked,
    output int          images_done
);

    localparam logic [7:0] JPEG_MARK = 8'hFF;
    localparam logic [7:0] JPEG_EOI  = 8'hD9;
    localparam int         MAX_PRINTS = 50;

    localparam logic [0:4][7:0] CAPTURE_CMD = {8'h56, 8'h00, 8'h36, 8'h01, 8'h00};
    localparam logic [0:4][7:0] CAPTURE_ACK = {8'h76, 8'h00, 8'h36, 8'h00, 8'h00};
    localparam logic [0:4][7:0] SIZE_CMD    = {8'h56, 8'h00, 8'h34, 8'h01, 8'h00};
    localparam logic [0:6][7:0] SIZE_ACK    = {8'h76, 8'h00, 8'h34, 8'h00, 8'h04,
                                               8'h00, 8'h00};
    localparam logic [0:4][7:0] FRAME_ACK   = {8'h76, 8'h00, 8'h32, 8'h00, 8'h00};
    localparam logic [0:15][7:0] CHUNK_REQ  = {8'h56, 8'h00, 8'h32, 8'h0C,
                                               8'h00, 8'h0A, 8'h00, 8'h00,
                                               8'h00, 8'h00, 8'h00, 8'h00,
                                               8'h00, 8'h00, 8'h00, 8'h0A};

    typedef enum logic [2:0] {
        SESS_IDLE,
        SESS_CAPTURE,
        SESS_SIZE,
        SESS_HEADER,
        SESS_DATA,
        SESS_FOOTER
    } session_phase_t;

    typedef struct packed {
        scjf_pkg::kind_t   kind;
        logic [7:0]        data;
        scjf_pkg::status_t status;
        logic [15:0]       img_size;
        logic [15:0]       count;
        logic              last;
    } camera_result_t;

    camera_result_t results_due[$];

    session_phase_t sess_phase;
    logic [5:0]     byte_idx;
    logic [15:0]    read_addr;
    logic [15:0]    size_word;
    logic [7:0]     prev_byte;
    logic           end_mark;
    logic           bad_reply;
    logic [15:0]    image_count;
    int             run_len;

    task automatic clear_session();
        sess_phase  = SESS_IDLE;
        byte_idx    = '0;
        read_addr   = '0;
        size_word   = '0;
        prev_byte   = '0;
        end_mark    = 1'b0;
        bad_reply   = 1'b0;
        image_count = '0;
    endtask

    task automatic push_result(input scjf_pkg::kind_t k, input logic [7:0] d,
                               input scjf_pkg::status_t st, input logic [15:0] sz);
        camera_result_t r;
        r.kind     = k;
        r.data     = d;
        r.status   = st;
        r.img_size = sz;
        r.count    = image_count;
        r.last     = 1'b0;
        results_due.push_back(r);
        run_len++;
    endtask

    task automatic push_chunk_request();
        logic [0:15][7:0] req;
        logic [15:0]      len;
        len     = 16'(CHUNK_BYTES);
        req     = CHUNK_REQ;
        req[8]  = read_addr[15:8];
        req[9]  = read_addr[7:0];
        req[12] = len[15:8];
        req[13] = len[7:0];
        for (int i = 0; i < scjf_pkg::CHUNK_CMD_LEN; i++)
            push_result(scjf_pkg::KIND_TX, req[i], scjf_pkg::ST_NONE, 16'h0);
    endtask

    task automatic emit_image_byte(input logic [7:0] b);
        if (!end_mark) begin
            image_count = image_count + 16'd1;
            push_result(scjf_pkg::KIND_IMAGE, b, scjf_pkg::ST_NONE, 16'h0);
            if (prev_byte == JPEG_MARK && b == JPEG_EOI)
                end_mark = 1'b1;
            prev_byte = b;
        end
    endtask

    task automatic advance_session(input logic op, input logic [7:0] b);
        logic [5:0]     pos;
        camera_result_t r;
        run_len = 0;
        pos     = byte_idx;
        if (op == scjf_pkg::OP_START) begin
            clear_session();
            sess_phase = SESS_CAPTURE;
            for (int i = 0; i < scjf_pkg::CMD_LEN; i++)
                push_result(scjf_pkg::KIND_TX, CAPTURE_CMD[i], scjf_pkg::ST_NONE, 16'h0);
        end else begin
            case (sess_phase)
                SESS_CAPTURE: begin
                    if (pos < scjf_pkg::CMD_LEN && b != CAPTURE_ACK[pos[2:0]])
                        bad_reply = 1'b1;
                    pos++;
                    if (pos == scjf_pkg::CMD_LEN) begin
                        pos = '0;
                        if (bad_reply) begin
                            push_result(scjf_pkg::KIND_STATUS, 8'h00,
                                        scjf_pkg::ST_CAP_FAIL, 16'h0);
                            sess_phase = SESS_IDLE;
                        end else begin
                            for (int i = 0; i < scjf_pkg::CMD_LEN; i++)
                                push_result(scjf_pkg::KIND_TX, SIZE_CMD[i],
                                            scjf_pkg::ST_NONE, 16'h0);
                            sess_phase = SESS_SIZE;
                        end
                        bad_reply = 1'b0;
                    end
                end
                SESS_SIZE: begin
                    if (pos < scjf_pkg::SIZE_HDR_LEN) begin
                        if (b != SIZE_ACK[pos[2:0]])
                            bad_reply = 1'b1;
                    end else if (pos == scjf_pkg::SIZE_HDR_LEN) begin
                        size_word = {b, 8'h00};
                    end else begin
                        size_word = size_word | {8'h00, b};
                    end
                    pos++;
                    if (pos == scjf_pkg::SIZE_REPLY_LEN) begin
                        pos = '0;
                        if (bad_reply) begin
                            size_word = '0;
                            push_result(scjf_pkg::KIND_STATUS, 8'h00,
                                        scjf_pkg::ST_SIZE_BAD, 16'h0);
                        end else begin
                            push_result(scjf_pkg::KIND_STATUS, 8'h00,
                                        scjf_pkg::ST_SIZE, size_word);
                        end
                        bad_reply = 1'b0;
                        push_chunk_request();
                        sess_phase = SESS_HEADER;
                    end
                end
                SESS_HEADER: begin
                    if (pos < scjf_pkg::FRAME_LEN && b != FRAME_ACK[pos[2:0]])
                        bad_reply = 1'b1;
                    pos++;
                    if (pos == scjf_pkg::FRAME_LEN) begin
                        pos = '0;
                        if (bad_reply) begin
                            push_result(scjf_pkg::KIND_STATUS, 8'h00,
                                        scjf_pkg::ST_HEAD_BAD, 16'h0);
                            for (int i = 0; i < CHUNK_BYTES; i++)
                                emit_image_byte(8'h00);
                            sess_phase = SESS_FOOTER;
                        end else begin
                            sess_phase = SESS_DATA;
                        end
                        bad_reply = 1'b0;
                    end
                end
                SESS_DATA: begin
                    emit_image_byte(b);
                    pos++;
                    if (pos == CHUNK_BYTES) begin
                        pos        = '0;
                        sess_phase = SESS_FOOTER;
                    end
                end
                SESS_FOOTER: begin
                    if (pos < scjf_pkg::FRAME_LEN && b != FRAME_ACK[pos[2:0]])
                        bad_reply = 1'b1;
                    pos++;
                    if (pos == scjf_pkg::FRAME_LEN) begin
                        pos = '0;
                        if (bad_reply)
                            push_result(scjf_pkg::KIND_STATUS, 8'h00,
                                        scjf_pkg::ST_FOOT_BAD, 16'h0);
                        bad_reply = 1'b0;
                        if (end_mark) begin
                            push_result(scjf_pkg::KIND_STATUS, 8'h00,
                                        scjf_pkg::ST_DONE, 16'h0);
                            images_done++;
                            sess_phase = SESS_IDLE;
                        end else begin
                            read_addr = read_addr + 16'(CHUNK_BYTES);
                            push_chunk_request();
                            sess_phase = SESS_HEADER;
                        end
                    end
                end
                default: begin
                    sess_phase = SESS_IDLE;
                    pos        = '0;
                end
            endcase
            byte_idx = pos;
        end
        if (run_len > 0) begin
            r      = results_due.pop_back();
            r.last = 1'b1;
            results_due.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (fail_count < MAX_PRINTS)
            $display("[%0t] result %0d: %s is %0h, should be %0h",
                     $time, results_checked, what, got, want);
        fail_count++;
    endtask

    task automatic check_result();
        camera_result_t want;
        if (results_due.size() == 0) begin
            report_mismatch("unexpected transfer, data", m_tdata[7:0], 0);
        end else begin
            want = results_due.pop_front();
            if (m_tuser !== want.kind)
                report_mismatch("kind", m_tuser, want.kind);
            if (m_tdata[7:0] !== want.data)
                report_mismatch("data_byte", m_tdata[7:0], want.data);
            if (m_tdata[10:8] !== want.status)
                report_mismatch("status", m_tdata[10:8], want.status);
            if (m_tdata[26:11] !== want.img_size)
                report_mismatch("image_size", m_tdata[26:11], want.img_size);
            if (m_tdata[42:27] !== want.count)
                report_mismatch("bytes_emitted", m_tdata[42:27], want.count);
            if (m_tdata[47:43] !== 5'd0)
                report_mismatch("tdata padding", m_tdata[47:43], 0);
            if (m_tlast !== want.last)
                report_mismatch("tlast", m_tlast, want.last);
        end
        results_checked++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_session();
            results_due.delete();
            pending <= 0;
        end else begin
            if (s_tvalid && s_tready)
                advance_session(s_tuser[0], s_tdata);
            if (m_tvalid && m_tready)
                check_result();
            pending <= results_due.size();
        end
    end

endmodule

// ===== dv/serial_camera_jpeg_fetch_core_tb.sv =====
// ----------------------------------------------------------------------------
// serial_camera_jpeg_fetch_core_tb: testbench top of the JPEG fetch core
// Plays the camera side: start transfers and reply bytes for capture, size
// and chunk reads. A short directed opening hits idle bytes, a failed capture
// and a restart. Random sessions follow with faulty replies, aborted reads and
// end marks inside and across chunks. Stalls on both channels change in three
// stages, with one long output hold and one drain pause.
// ----------------------------------------------------------------------------
module serial_camera_jpeg_fetch_core_tb;

    localparam int CHUNK_BYTES    = scjf_pkg::CHUNK_BYTES_DEF;
    localparam int RESET_CYCLES   = 11;
    localparam int ITEM_TARGET    = 480;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 64;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [7:0] JPEG_MARK = 8'hFF;
    localparam logic [7:0] JPEG_EOI  = 8'hD9;

    localparam logic [0:6][7:0] CAP_ACK   = {8'h76, 8'h00, 8'h36, 8'h00, 8'h00,
                                             8'h00, 8'h00};
    localparam logic [0:6][7:0] SIZE_ACK  = {8'h76, 8'h00, 8'h34, 8'h00, 8'h04,
                                             8'h00, 8'h00};
    localparam logic [0:6][7:0] FRAME_ACK = {8'h76, 8'h00, 8'h32, 8'h00, 8'h00,
                                             8'h00, 8'h00};

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic [0:0]  s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int fail_count;
    int pending;
    int results_checked;
    int images_done;

    int tx_idle_pct = 9;
    int rx_idle_pct = 85;
    int items_sent  = 0;
    int sessions    = 0;
    int hold_left   = 0;
    int quiet_cycles = 0;
    bit hold_go     = 1'b0;
    bit hold_done   = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    serial_camera_jpeg_fetch_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    serial_camera_jpeg_fetch_core_checker #(
        .CHUNK_BYTES (CHUNK_BYTES)
    ) i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .images_done     (images_done)
    );

    // receiver: random stalls, one long hold on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_go && !hold_done) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, pending);
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic op, input logic [7:0] b, input bit counted);
        if (items_sent < 160) begin
            tx_idle_pct = 9;
            rx_idle_pct = 85;
        end else if (items_sent < 320) begin
            tx_idle_pct = 85;
            rx_idle_pct = 9;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (counted)
            items_sent++;
    endtask

    // drop valid and hold until every queued result has come out
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
    endtask

    task automatic send_ack(input logic [0:6][7:0] seq, input int len, input int fault);
        logic [7:0] flip;
        for (int i = 0; i < len; i++) begin
            flip = (i == fault) ? 8'($urandom_range(255, 1)) : 8'h00;
            send_item(scjf_pkg::OP_BYTE, seq[i] ^ flip, 1'b1);
        end
    endtask

    function automatic int pick_fault(input int odds, input int span);
        return ($urandom_range(odds - 1) == 0) ? $urandom_range(span - 1) : -1;
    endfunction

    task automatic run_session();
        int         n_chunks;
        int         ff_chunk;
        int         ff_pos;
        int         d9_chunk;
        int         d9_pos;
        int         fault;
        logic [7:0] b;
        send_item(scjf_pkg::OP_START, 8'($urandom_range(255)), 1'b1);
        fault = pick_fault(12, scjf_pkg::CMD_LEN);
        send_ack(CAP_ACK, scjf_pkg::CMD_LEN, fault);
        if (fault >= 0)
            return;
        send_ack(SIZE_ACK, scjf_pkg::SIZE_HDR_LEN, pick_fault(8, scjf_pkg::SIZE_HDR_LEN));
        send_item(scjf_pkg::OP_BYTE, 8'($urandom_range(255)), 1'b1);
        send_item(scjf_pkg::OP_BYTE, 8'($urandom_range(255)), 1'b1);
        // abort: junk bytes, then leave the session open
        if ($urandom_range(11) == 0) begin
            repeat ($urandom_range(20, 1))
                send_item(scjf_pkg::OP_BYTE, 8'($urandom_range(255)), 1'b1);
            return;
        end
        n_chunks = ($urandom_range(5) == 0) ? 3 : $urandom_range(2, 1);
        d9_chunk = n_chunks - 1;
        if (n_chunks > 1 && $urandom_range(2) == 0) begin
            ff_chunk = n_chunks - 2;
            ff_pos   = CHUNK_BYTES - 1;
            d9_pos   = 0;
        end else begin
            ff_chunk = d9_chunk;
            d9_pos   = $urandom_range(CHUNK_BYTES - 1, 1);
            ff_pos   = d9_pos - 1;
        end
        if ($urandom_range(9) == 0)
            d9_chunk = -1;
        for (int c = 0; c < n_chunks; c++) begin
            fault = pick_fault(10, scjf_pkg::FRAME_LEN);
            send_ack(FRAME_ACK, scjf_pkg::FRAME_LEN, fault);
            if (fault >= 0) begin
                send_ack(FRAME_ACK, scjf_pkg::FRAME_LEN,
                         pick_fault(10, scjf_pkg::FRAME_LEN));
                continue;
            end
            for (int k = 0; k < CHUNK_BYTES; k++) begin
                b = 8'($urandom_range(255));
                if (c == ff_chunk && k == ff_pos)
                    b = JPEG_MARK;
                if (c == d9_chunk && k == d9_pos)
                    b = JPEG_EOI;
                send_item(scjf_pkg::OP_BYTE, b, 1'b1);
            end
            send_ack(FRAME_ACK, scjf_pkg::FRAME_LEN, pick_fault(10, scjf_pkg::FRAME_LEN));
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // idle bytes, start with a stray rx_byte, failed capture
        send_item(scjf_pkg::OP_BYTE, 8'h00, 1'b0);
        send_item(scjf_pkg::OP_BYTE, 8'hFF, 1'b0);
        send_item(scjf_pkg::OP_START, 8'hFF, 1'b1);
        send_ack(CAP_ACK, scjf_pkg::CMD_LEN, scjf_pkg::CMD_LEN - 1);
        // restart mid-capture, then a bad size reply with extreme size bytes
        send_item(scjf_pkg::OP_START, 8'h00, 1'b1);
        send_ack(CAP_ACK, 2, -1);
        send_item(scjf_pkg::OP_START, 8'h5A, 1'b1);
        send_ack(CAP_ACK, scjf_pkg::CMD_LEN, -1);
        send_ack(SIZE_ACK, scjf_pkg::SIZE_HDR_LEN, 4);
        send_item(scjf_pkg::OP_BYTE, 8'hFF, 1'b1);
        send_item(scjf_pkg::OP_BYTE, 8'hFF, 1'b1);

        while (items_sent < ITEM_TARGET) begin
            if (sessions == 1)
                hold_go <= 1'b1;
            if (sessions == 3)
                wait_for_results();
            repeat ($urandom_range(2))
                send_item(scjf_pkg::OP_BYTE, 8'($urandom_range(255)), 1'b0);
            run_session();
            sessions++;
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Run covered %0d input transfers in %0d camera sessions and %0d checked results,",
                 items_sent, sessions, results_checked);
        $display("with %0d images completed under sender, receiver and long output stalls.",
                 images_done);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
